// ===== rtl/rafp_pkg.sv =====
// shared types and constants for the ranging/angle frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package rafp_pkg;

   // sizes
   localparam int NUM_NODES  = 3;
   localparam int AGE_BITS   = 16;
   localparam int NUM_SLOTS  = 3;
   localparam int REC_BASE   = 21;
   localparam int REC_DEPTH  = 31;
   localparam int REC_STRIDE = 11;
   localparam int CMP_BITS   = (AGE_BITS > 16) ? AGE_BITS : 16;

   // header and length bytes
   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'h07;
   localparam logic [7:0] LEN_SHORT   = 8'h21;
   localparam logic [7:0] LEN_MID     = 8'h2C;
   localparam logic [7:0] LEN_LONG    = 8'h37;

   // minimum frame length for each record slot
   localparam logic [7:0] SLOT_MIN_LEN [NUM_SLOTS] = '{LEN_SHORT, LEN_MID, LEN_LONG};

   // header positions
   localparam logic [5:0] POS_HUNT   = 6'd0;
   localparam logic [5:0] POS_SYNC   = 6'd1;
   localparam logic [5:0] POS_LEN_LO = 6'd2;
   localparam logic [5:0] POS_LEN_HI = 6'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd200;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic {
      KIND_MEAS    = 1'b0,
      KIND_TIMEOUT = 1'b1
   } kind_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [1:0]         node_id;
      logic [7:0]         role;
      logic signed [23:0] distance_mm;
      logic signed [15:0] angle_centideg;
      logic [7:0]         first_path_rssi;
      logic [7:0]         receive_rssi;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         node_id;
      logic [7:0]         role;
      logic signed [23:0] distance_mm;
      logic signed [15:0] angle_centideg;
      logic [7:0]         first_path_rssi;
      logic [7:0]         receive_rssi;
   } rec_type;

   // records of a frame that just passed its checksum
   typedef struct packed {
      logic [NUM_SLOTS-1:0]    hit;
      rec_type [NUM_SLOTS-1:0] rec;
   } meas_type;

endpackage

`default_nettype wire

// ===== rtl/rafp_frame.sv =====
// header hunt, length check, running byte sum and record byte store
// depends on rafp_pkg
`default_nettype none

module rafp_frame
   import rafp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   input  wire logic [7:0] data_byte,
   output meas_type        meas
);

   logic [5:0] pos_ff, pos_in;
   logic [5:0] len_ff, len_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] rec_ff [REC_DEPTH];
   logic       store;
   logic [4:0] wr_idx;
   logic       frame_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         len_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         rec_ff[wr_idx] <= data_byte;
      end
   end

   always_comb begin
      logic restart;
      logic advance;
      restart  = 1'b0;
      advance  = 1'b0;
      store    = 1'b0;
      frame_ok = 1'b0;
      pos_in   = pos_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      wr_idx   = 5'(pos_ff - 6'(REC_BASE));
      if (byte_valid) begin
         if (pos_ff == POS_HUNT) begin
            restart = 1'b1;
         end else if (pos_ff == POS_SYNC) begin
            if (data_byte != SYNC_SECOND) restart = 1'b1;
            else advance = 1'b1;
         end else if (pos_ff == POS_LEN_LO) begin
            if (data_byte != LEN_SHORT && data_byte != LEN_MID && data_byte != LEN_LONG) begin
               restart = 1'b1;
            end else begin
               len_in  = data_byte[5:0];
               advance = 1'b1;
            end
         end else if (pos_ff == POS_LEN_HI) begin
            if (data_byte != 8'd0) restart = 1'b1;
            else advance = 1'b1;
         end else if ({1'b0, pos_ff} + 7'd1 >= {1'b0, len_ff}) begin
            // checksum byte closes the frame either way
            pos_in   = POS_HUNT;
            len_in   = '0;
            sum_in   = '0;
            frame_ok = (sum_ff == data_byte);
         end else begin
            store   = (pos_ff >= 6'(REC_BASE)) && (pos_ff < 6'(REC_BASE + REC_DEPTH));
            advance = 1'b1;
         end

         if (restart) begin
            len_in = '0;
            if (data_byte == SYNC_FIRST) begin
               pos_in = POS_SYNC;
               sum_in = SYNC_FIRST;
            end else begin
               pos_in = POS_HUNT;
               sum_in = '0;
            end
         end
         if (advance) begin
            sum_in = sum_ff + data_byte;
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   // record fields at fixed offsets of the store
   always_comb begin
      logic [7:0] id;
      logic       id_ok;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         id = rec_ff[s*REC_STRIDE + 1];
         if (s == 0) id_ok = (id == 8'd0);
         else id_ok = (id == 8'd1 || id == 8'd2);
         meas.hit[s] = frame_ok && id_ok && (id < 8'(NUM_NODES))
                       && ({2'b00, len_ff} >= SLOT_MIN_LEN[s]);
         meas.rec[s].node_id         = id[1:0];
         meas.rec[s].role            = rec_ff[s*REC_STRIDE];
         meas.rec[s].distance_mm     = {rec_ff[s*REC_STRIDE + 4], rec_ff[s*REC_STRIDE + 3],
                                        rec_ff[s*REC_STRIDE + 2]};
         meas.rec[s].angle_centideg  = {rec_ff[s*REC_STRIDE + 6], rec_ff[s*REC_STRIDE + 5]};
         meas.rec[s].first_path_rssi = rec_ff[s*REC_STRIDE + 7];
         meas.rec[s].receive_rssi    = rec_ff[s*REC_STRIDE + 8];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rafp_age.sv =====
// per-node age counters, saturating, with timeout compare on each tick
// depends on rafp_pkg
`default_nettype none

module rafp_age
   import rafp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tick,
   input  wire logic [NUM_NODES-1:0] clear,
   input  wire logic [15:0]          timeout_ticks,
   output logic [NUM_SLOTS-1:0]      timed_out
);

   logic [AGE_BITS-1:0] age_ff [NUM_NODES];
   logic [AGE_BITS-1:0] age_in [NUM_NODES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_NODES; n++) age_ff[n] <= '1;
      end else begin
         for (int n = 0; n < NUM_NODES; n++) age_ff[n] <= age_in[n];
      end
   end

   always_comb begin
      logic [AGE_BITS-1:0] aged;
      timed_out = '0;
      for (int n = 0; n < NUM_NODES; n++) begin
         aged      = (age_ff[n] == '1) ? age_ff[n] : age_ff[n] + 1'b1;
         age_in[n] = age_ff[n];
         if (clear[n]) begin
            age_in[n] = '0;
         end else if (tick) begin
            age_in[n]    = aged;
            timed_out[n] = CMP_BITS'(aged) > CMP_BITS'(timeout_ticks);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rafp_result_queue.sv =====
// result register: holds the up to three results of one item and hands them out one per beat
// depends on rafp_pkg
`default_nettype none

module rafp_result_queue
   import rafp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic                 load_tick,
   input  wire meas_type             meas,
   input  wire logic [NUM_SLOTS-1:0] timed_out,
   output logic                      can_load,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data
);

   rsp_type              slot_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] pend_ff, pend_in;
   logic [NUM_SLOTS-1:0] cur;
   logic [NUM_SLOTS-1:0] rest;
   logic [NUM_SLOTS-1:0] pend_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (load_tick) begin
               slot_ff[s] <= '{kind: KIND_TIMEOUT, node_id: 2'(s), default: '0};
            end else begin
               slot_ff[s].kind            <= KIND_MEAS;
               slot_ff[s].node_id         <= meas.rec[s].node_id;
               slot_ff[s].role            <= meas.rec[s].role;
               slot_ff[s].distance_mm     <= meas.rec[s].distance_mm;
               slot_ff[s].angle_centideg  <= meas.rec[s].angle_centideg;
               slot_ff[s].first_path_rssi <= meas.rec[s].first_path_rssi;
               slot_ff[s].receive_rssi    <= meas.rec[s].receive_rssi;
               slot_ff[s].last            <= 1'b0;
            end
         end
      end
   end

   always_comb begin
      // lowest pending slot goes out first
      cur        = pend_ff & (~pend_ff + 1'b1);
      rest       = pend_ff & ~cur;
      rsp_valid  = (pend_ff != '0);
      pend_after = (rsp_valid && rsp_ready) ? rest : pend_ff;
      can_load   = (pend_after == '0);
      pend_in    = pend_after;
      if (load) begin
         pend_in = load_tick ? timed_out : meas.hit;
      end
      rsp_data = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (cur[s]) rsp_data = slot_ff[s];
      end
      rsp_data.last = (rest == '0);
   end

endmodule

`default_nettype wire

// ===== rtl/ranging_angle_frame_parser_unit.sv =====
// top level of the ranging/angle frame parser
// depends on rafp_pkg, rafp_frame, rafp_age, rafp_result_queue
//
//   channel | ports                           | dir | carries
//   --------+---------------------------------+-----+-------------------------------
//   request | req_valid req_ready req_data    | in  | serial byte or time tick
//   result  | rsp_valid rsp_ready rsp_data    | out | measurement or timeout result
//   csr     | csr_valid csr_ready csr_wdata   | in  | timeout_ticks (16 bit)
//
// one request beat per cycle when req_ready is high; results are registered next cycle
// an item yields zero to three result beats, one per cycle while rsp_ready is high;
// a new request is taken in the cycle the last waiting result leaves, so the request
// side waits while an item's results are pending, also in every cycle rsp_ready is low
// synchronous reset: header hunt, all node ages saturated, timeout_ticks = 200
// csr writes are always taken
`default_nettype none

module ranging_angle_frame_parser_unit
   import rafp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0]          timeout_ff;
   logic                 accept;
   logic                 is_tick;
   meas_type             meas;
   logic [NUM_SLOTS-1:0] timed_out;
   logic [NUM_NODES-1:0] clear;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_wdata;
      end
   end

   assign accept  = req_valid && req_ready;
   assign is_tick = (req_data.opcode == OP_TICK);

   // a checked record restarts its node's age
   always_comb begin
      clear = '0;
      for (int n = 0; n < NUM_NODES; n++) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (meas.hit[s] && meas.rec[s].node_id == 2'(n)) clear[n] = 1'b1;
         end
      end
   end

   rafp_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept && !is_tick),
      .data_byte  (req_data.data_byte),
      .meas       (meas)
   );

   rafp_age u_age (
      .clock         (clock),
      .reset         (reset),
      .tick          (accept && is_tick),
      .clear         (clear),
      .timeout_ticks (timeout_ff),
      .timed_out     (timed_out)
   );

   rafp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_tick (is_tick),
      .meas      (meas),
      .timed_out (timed_out),
      .can_load  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== dv/tb_ranging_angle_frame_parser_unit.sv =====
// self-checking bench for ranging_angle_frame_parser_unit: serial frames and ticks in,
// measurement and timeout results out, checked against an in-bench parser model
// depends on rafp_pkg and the rtl of the block
module tb_ranging_angle_frame_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rafp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIN, FILL_MAX} fill_type;
   typedef enum logic [1:0] {SINK_FREE, SINK_RANDOM, SINK_SLOW} sink_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   // parser model state
   logic [5:0]          parse_pos;
   logic [7:0]          parse_len;
   logic [7:0]          parse_sum;
   logic [7:0]          frame_rec [REC_DEPTH];
   logic [AGE_BITS-1:0] node_ticks [NUM_NODES];
   logic [15:0]         timeout_limit;

   rsp_type expected_results [$];
   int      error_count    = 0;
   int      items_sent     = 0;
   int      burst_left     = 1;
   int      cycle_count    = 0;

   sink_type    sink = SINK_FREE;
   logic [31:0] sink_cycle = '0;

   ranging_angle_frame_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void restart_hunt(input logic [7:0] b);
      parse_len = '0;
      if (b == SYNC_FIRST) begin
         parse_pos = POS_SYNC;
         parse_sum = SYNC_FIRST;
      end else begin
         parse_pos = POS_HUNT;
         parse_sum = '0;
      end
   endfunction

   function automatic void predict_item(input req_type item);
      rsp_type    outs [$];
      rsp_type    r;
      logic [5:0] p;
      logic [7:0] b;
      logic [7:0] id;
      logic       advance;
      int         i;
      p = parse_pos;
      b = item.data_byte;
      advance = 1'b1;
      if (item.opcode == OP_TICK) begin
         for (int nd = 0; nd < NUM_NODES; nd++) begin
            if (node_ticks[nd] != '1)
               node_ticks[nd] = node_ticks[nd] + 1'b1;
            if (node_ticks[nd] > timeout_limit) begin
               r = '0;
               r.kind = KIND_TIMEOUT;
               r.node_id = nd[1:0];
               outs.push_back(r);
            end
         end
      end else begin
         case (p)
            POS_HUNT: begin
               restart_hunt(b);
               advance = 1'b0;
            end
            POS_SYNC: begin
               if (b != SYNC_SECOND) begin
                  restart_hunt(b);
                  advance = 1'b0;
               end
            end
            POS_LEN_LO: begin
               if (b != LEN_SHORT && b != LEN_MID && b != LEN_LONG) begin
                  restart_hunt(b);
                  advance = 1'b0;
               end else begin
                  parse_len = b;
               end
            end
            POS_LEN_HI: begin
               if (b != 8'h00) begin
                  restart_hunt(b);
                  advance = 1'b0;
               end
            end
            default: begin
               if (int'(p) + 1 >= int'(parse_len)) begin
                  // checksum beat ends the frame either way
                  advance = 1'b0;
                  if (parse_sum == b) begin
                     for (int s = 0; s < NUM_SLOTS; s++) begin
                        i = s * REC_STRIDE;
                        id = frame_rec[i + 1];
                        if (parse_len >= SLOT_MIN_LEN[s] &&
                            ((s == 0) ? (id == 8'd0) : (id == 8'd1 || id == 8'd2)) &&
                            id < NUM_NODES) begin
                           r = '0;
                           r.kind            = KIND_MEAS;
                           r.node_id         = id[1:0];
                           r.role            = frame_rec[i];
                           r.distance_mm     = {frame_rec[i + 4], frame_rec[i + 3],
                                                frame_rec[i + 2]};
                           r.angle_centideg  = {frame_rec[i + 6], frame_rec[i + 5]};
                           r.first_path_rssi = frame_rec[i + 7];
                           r.receive_rssi    = frame_rec[i + 8];
                           node_ticks[id]    = '0;
                           outs.push_back(r);
                        end
                     end
                  end
                  parse_pos = POS_HUNT;
                  parse_len = '0;
                  parse_sum = '0;
               end else if (p >= REC_BASE && p - REC_BASE < REC_DEPTH) begin
                  frame_rec[p - REC_BASE] = b;
               end
            end
         endcase
         if (advance) begin
            parse_sum = parse_sum + b;
            parse_pos = p + 6'd1;
         end
      end
      if (outs.size() > 0)
         outs[outs.size() - 1].last = 1'b1;
      foreach (outs[k])
         expected_results.push_back(outs[k]);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         report("result beat with nothing pending, kind/node", {got.kind, got.node_id}, '0);
         return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
         report("kind", got.kind, want.kind);
      if (got.node_id !== want.node_id)
         report("node_id", got.node_id, want.node_id);
      if (got.role !== want.role)
         report("role", got.role, want.role);
      if (got.distance_mm !== want.distance_mm)
         report("distance_mm", got.distance_mm, want.distance_mm);
      if (got.angle_centideg !== want.angle_centideg)
         report("angle_centideg", got.angle_centideg, want.angle_centideg);
      if (got.first_path_rssi !== want.first_path_rssi)
         report("first_path_rssi", got.first_path_rssi, want.first_path_rssi);
      if (got.receive_rssi !== want.receive_rssi)
         report("receive_rssi", got.receive_rssi, want.receive_rssi);
      if (got.last !== want.last)
         report("last", got.last, want.last);
   endtask

   // sampled at the edge, so every handshake sees pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_result(rsp_data);
         if (csr_valid && csr_ready)
            timeout_limit = csr_wdata;
         if (req_valid && req_ready)
            predict_item(req_data);
      end
   end

   // result sink with its own stall pattern
   always @(posedge clock) begin
      sink_cycle <= sink_cycle + 1;
      if (sink_cycle[5:0] == 6'd0)
         sink <= sink_type'($urandom_range(0, 2));
      case (sink)
         SINK_FREE:   rsp_ready <= 1'b1;
         SINK_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         default:     rsp_ready <= (sink_cycle % 6 == 0);
      endcase
   end

   // ---------------------------------------------------------------- driving

   task automatic send_item(input op_type op, input logic [7:0] b);
      req_type beat;
      beat.opcode    = op;
      beat.data_byte = b;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic wait_for_quiet();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (expected_results.size() != 0) @(posedge clock);
      // a beat with no result may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timeout_ticks(input logic [15:0] value);
      wait_for_quiet();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input logic [7:0] len, input logic [7:0] id0, input logic [7:0] id1,
                             input logic [7:0] id2, input fill_type fill, input bit bad_sum,
                             input int cut, input int tick_pct);
      logic [7:0] fb  [55];
      logic [7:0] ids [3];
      logic [7:0] pat [8];
      logic [7:0] sum;
      int         off;
      int         stop;
      ids = '{id0, id1, id2};
      pat = '{8{8'h00}};
      case (fill)
         FILL_ONES: pat = '{8{8'hFF}};
         FILL_MIN:  pat = '{8'h80, 8'h00, 8'h00, 8'h80, 8'h00, 8'h80, 8'h80, 8'h80};
         FILL_MAX:  pat = '{8'h7F, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h7F, 8'h7F, 8'h7F};
         default: ;
      endcase
      foreach (fb[k])
         fb[k] = 8'($urandom_range(0, 255));
      fb[0] = SYNC_FIRST;
      fb[1] = SYNC_SECOND;
      fb[2] = len;
      fb[3] = 8'h00;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         off = REC_BASE + s * REC_STRIDE;
         fb[off + 1] = ids[s];
         if (fill != FILL_RANDOM) begin
            // pattern order: role, distance lo..hi, angle lo..hi, rssi pair
            fb[off] = pat[0];
            for (int k = 1; k < 8; k++)
               fb[off + k + 1] = pat[k];
         end
      end
      sum = '0;
      for (int k = 0; k < int'(len) - 1; k++)
         sum = sum + fb[k];
      // a bad sum is sent as a sync byte (or the byte after it if the true sum is one) that must not start a new header
      fb[len - 1] = !bad_sum ? sum : (sum == SYNC_FIRST) ? SYNC_FIRST + 8'd1 : SYNC_FIRST;
      stop = (cut > 0 && cut < int'(len)) ? cut : int'(len);
      for (int k = 0; k < stop; k++) begin
         if ($urandom_range(0, 99) < tick_pct)
            send_item(OP_TICK, 8'($urandom_range(0, 255)));
         send_item(OP_BYTE, fb[k]);
      end
   endtask

   function automatic logic [7:0] pick_len();
      case ($urandom_range(0, 2))
         0:       return LEN_SHORT;
         1:       return LEN_MID;
         default: return LEN_LONG;
      endcase
   endfunction

   function automatic logic [7:0] pick_id(input bit first);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7)
         return first ? 8'd0 : 8'($urandom_range(1, 2));
      else if (sel < 9)
         return 8'($urandom_range(0, 3));
      return 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_saturated_ages();
      // ages come out of reset saturated, so every tick times out all nodes unless timeout_ticks is 16'hFFFF
      send_item(OP_TICK, 8'h00);
      set_timeout_ticks(16'hFFFE);
      send_item(OP_TICK, 8'hFF);
      send_item(OP_TICK, 8'hA5);
      set_timeout_ticks(16'hFFFF);
      send_item(OP_TICK, 8'h5A);
      send_item(OP_TICK, 8'h00);
      set_timeout_ticks(TIMEOUT_RESET);
   endtask

   task automatic test_header_hunt();
      logic [7:0] noise [16];
      noise = '{8'h55, 8'h55, 8'h07, 8'h21, 8'h22,
                8'h55, 8'h07, 8'h37, 8'h55,
                8'h07, 8'h2C, 8'h01,
                8'h55, 8'h07, 8'h55, 8'h07};
      foreach (noise[k])
         send_item(OP_BYTE, noise[k]);
      // the bytes above leave a partial header; the frame's sync byte restarts the hunt
      send_frame(LEN_SHORT, 8'd0, 8'd0, 8'd0, FILL_RANDOM, 1'b0, 0, 0);
   endtask

   task automatic test_record_slots();
      send_frame(LEN_LONG, 8'd0, 8'd2, 8'd1, FILL_MIN,    1'b0, 0, 0);
      // ids in the wrong slot give nothing
      send_frame(LEN_MID,  8'd1, 8'd0, 8'd3, FILL_RANDOM, 1'b0, 0, 0);
   endtask

   task automatic test_bad_checksum();
      send_frame(LEN_SHORT, 8'd0, 8'd0, 8'd0, FILL_RANDOM, 1'b1, 0, 0);
      send_item(OP_BYTE, SYNC_SECOND);
      send_item(OP_BYTE, LEN_SHORT);
      send_item(OP_BYTE, 8'h00);
      send_frame(LEN_SHORT, 8'd0, 8'd0, 8'd0, FILL_RANDOM, 1'b0, 0, 0);
   endtask

   task automatic test_timeout_extremes();
      set_timeout_ticks(16'd0);
      send_item(OP_TICK, 8'h00);
      send_frame(LEN_LONG, 8'd0, 8'd1, 8'd2, FILL_MAX, 1'b0, 0, 0);
      send_item(OP_TICK, 8'h00);
      set_timeout_ticks(16'd2);
      repeat (4) send_item(OP_TICK, 8'hFF);
   endtask

   task automatic random_step();
      int         sel;
      logic [7:0] len;
      sel = $urandom_range(0, 99);
      len = pick_len();
      if (sel < 60) begin
         send_frame(len, pick_id(1'b1), pick_id(1'b0), pick_id(1'b0), FILL_RANDOM, 1'b0, 0, 4);
      end else if (sel < 70) begin
         if ($urandom_range(0, 1))
            send_frame(len, pick_id(1'b1), pick_id(1'b0), pick_id(1'b0), FILL_RANDOM,
                       1'b1, 0, 4);
         else
            send_frame(len, pick_id(1'b1), pick_id(1'b0), pick_id(1'b0), FILL_RANDOM,
                       1'b0, $urandom_range(1, int'(len) - 1), 4);
      end else if (sel < 85) begin
         repeat ($urandom_range(1, 4)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
               0:       send_item(OP_BYTE, SYNC_FIRST);
               1:       send_item(OP_BYTE, SYNC_SECOND);
               2:       send_item(OP_BYTE, pick_len());
               default: send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            endcase
         end
      end
   endtask

   task automatic test_random_traffic();
      logic [15:0] limits [4];
      int          phase;
      int          items_base;
      limits = '{16'd1, 16'd3, 16'($urandom_range(4, 300)), 16'($urandom_range(0, 65535))};
      phase = 0;
      items_base = items_sent;
      while (items_sent - items_base < 30) begin
         // each phase starts from a drained block
         set_timeout_ticks(limits[phase % 4]);
         random_step();
         phase++;
      end
      set_timeout_ticks(TIMEOUT_RESET);
   endtask

   task automatic finish_run();
      wait_for_quiet();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   endtask

   initial begin
      parse_pos = POS_HUNT;
      parse_len = '0;
      parse_sum = '0;
      foreach (node_ticks[n])
         node_ticks[n] = '1;
      timeout_limit = TIMEOUT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_saturated_ages();
      test_header_hunt();
      test_record_slots();
      test_bad_checksum();
      test_timeout_extremes();
      test_random_traffic();
      finish_run();
   end

endmodule

// ===== filelist.f =====
rtl/rafp_pkg.sv
rtl/rafp_frame.sv
rtl/rafp_age.sv
rtl/rafp_result_queue.sv
rtl/ranging_angle_frame_parser_unit.sv
dv/tb_ranging_angle_frame_parser_unit.sv
